[src/tcli_pkg.sv]
// Package for the lightness inversion pipeline: configuration index, byte and fraction constants.
// No dependencies; used by theme_color_lightness_invert.
`default_nettype none
package tcli_pkg;
    localparam int unsigned CFG_DARK_ENABLE   = 0;
    localparam int unsigned CFG_CONTRAST_DARK = 1;
    localparam int unsigned CFG_ADDR_W        = 1;
    localparam int unsigned BYTE_MAX          = 255;
    localparam int unsigned LUM_DEN           = 510;
endpackage
`default_nettype wire

[src/theme_color_lightness_invert.sv]
// Top level: RGB to HSL, lightness complement, HSL back to RGB, as a stream pipeline.
// Depends on tcli_pkg.
//
//  channel | beat content                            | handshake
//  s_axis  | tdata[23:0] color_in, tuser fixed_flag  | tvalid/tready
//  m_axis  | tdata[23:0] color_out                   | tvalid/tready
//  cfg     | cfg_index, cfg_data                     | cfg_we, no wait
//
// Seven register stages; a beat accepted at an edge is presented on m_axis from the last, out_reg.
// One beat per cycle is accepted while m_axis_tready is high or the output is empty.
// Divides multiply by a table (S, H) or constant (L) reciprocal; the multipliers set depth.
// Reset clears all valid bits and both configuration registers.
// A stall at the output freezes every stage, empty ones included, and holds s_axis_tready low.
`default_nettype none
module theme_color_lightness_invert #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tcli_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire logic                          cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [23:0]                   s_axis_tdata,  // color_in[23:0]
    input  wire logic                          s_axis_tuser,  // fixed_flag
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [23:0]                        m_axis_tdata   // color_out[23:0]
);
    import tcli_pkg::*;

    localparam int unsigned F = FRAC_BITS;
    localparam int unsigned W = F + 4;
    localparam longint ONE = 64'sd1 << F;
    localparam longint THIRD = (64'sd33333 << F) / 100000;
    localparam longint TWO3 = (64'sd66666 << F) / 100000;
    localparam int unsigned NST = 7;
    // With m = ceil(2^K / den) and n * den * 2^F < 2^K, floor(n * m >> (K - F)) is exact.
    localparam int unsigned KL = F + 18;
    localparam int unsigned KS = F + 16;
    localparam int unsigned KH = F + 22;
    localparam int unsigned RS_W = F + 17;
    localparam int unsigned RH_W = F + 20;
    localparam longint ML = ((64'sd1 << KL) + longint'(LUM_DEN) - 64'sd1) / longint'(LUM_DEN);

    logic dark_reg, contrast_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg     <= 1'b0;
            contrast_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ADDR_W'(CFG_DARK_ENABLE))
                dark_reg <= cfg_data;
            else if (cfg_index == CFG_ADDR_W'(CFG_CONTRAST_DARK))
                contrast_reg <= cfg_data;
        end
    end

    // Reciprocal tables: saturation by denominator, hue by max - min (denominator 6d).
    logic [RS_W-1:0] rcp_s [256];
    logic [RH_W-1:0] rcp_h [256];
    for (genvar k = 0; k < 256; k++)
    begin : g_rcp
        localparam longint DK = (k == 0) ? 64'sd1 : longint'(k);
        assign rcp_s[k] = RS_W'(((64'sd1 << KS) + DK - 64'sd1) / DK);
        assign rcp_h[k] = RH_W'(((64'sd1 << KH) + 6 * DK - 64'sd1) / (6 * DK));
    end

    function automatic logic signed [W+1:0] fmul(input logic signed [W+1:0] a,
                                                 input logic signed [W+1:0] b);
        logic neg;
        logic [2*W+3:0] ua, ub, m;
        begin
            neg  = (a < 0) != (b < 0);
            ua   = (a < 0) ? (2*W+4)'(-a) : (2*W+4)'(a);
            ub   = (b < 0) ? (2*W+4)'(-b) : (2*W+4)'(b);
            m    = (ua * ub) >> F;
            fmul = neg ? -$signed((W+2)'(m)) : $signed((W+2)'(m));
        end
    endfunction

    function automatic logic [7:0] tobyte(input logic signed [W+1:0] p);
        logic [W+9:0] x;
        begin
            x = (W+10)'($unsigned(p)) * (W+10)'(BYTE_MAX);
            if (p <= 0) tobyte = 8'd0;
            else if (p >= (W+2)'(ONE)) tobyte = 8'hFF;
            else tobyte = x[F+7:F];
        end
    endfunction

    function automatic logic signed [W+1:0] chan(input logic signed [W+1:0] t1,
        input logic signed [W+1:0] t2, input logic signed [W+1:0] t);
        logic signed [W+1:0] d6;
        begin
            d6 = (W+2)'((t1 - t2) * 6);
            if (t * 6 < ONE) chan = t2 + fmul(d6, t);
            else if (t * 2 < ONE) chan = t1;
            else if (t * 3 < 2 * ONE) chan = t2 + fmul(d6, (W+2)'(TWO3) - t);
            else chan = t2;
        end
    endfunction

    // Pipeline control: one valid bit per stage; advance when the last stage is empty or drains.
    logic [NST-1:0] vld_reg;
    logic           adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    // Stage 1: capture, decide, min and max.
    logic [23:0] c1_reg; logic inv1_reg; logic [7:0] mx1_reg, mn1_reg;
    logic [7:0] r0, g0, b0, mx0, mn0;
    always_comb
    begin
        r0 = s_axis_tdata[7:0]; g0 = s_axis_tdata[15:8]; b0 = s_axis_tdata[23:16];
        if (r0 >= g0 && r0 >= b0) mx0 = r0; else if (g0 >= b0) mx0 = g0; else mx0 = b0;
        if (r0 <= g0 && r0 <= b0) mn0 = r0; else if (g0 <= b0) mn0 = g0; else mn0 = b0;
    end
    // Stage 2: sum, difference, hue numerator and reciprocal lookups.
    logic [23:0] c2_reg; logic inv2_reg, grey2_reg;
    logic [8:0] sum2_reg; logic [7:0] dd2_reg; logic [10:0] hn2_reg;
    logic [RS_W-1:0] rs2_reg; logic [RH_W-1:0] rh2_reg;
    logic [8:0] sum1;
    logic [7:0] dd1, dens1;
    logic [11:0] hn1s;
    logic [7:0] r1, g1, b1;
    always_comb
    begin
        r1 = c1_reg[7:0]; g1 = c1_reg[15:8]; b1 = c1_reg[23:16];
        sum1  = 9'(mx1_reg) + 9'(mn1_reg);
        dd1   = mx1_reg - mn1_reg;
        dens1 = (sum1 < 9'(BYTE_MAX)) ? sum1[7:0] : 8'(9'(LUM_DEN) - sum1);
        if (mx1_reg == r1) hn1s = 12'(g1) - 12'(b1);
        else if (mx1_reg == g1) hn1s = 12'(2 * dd1) + 12'(b1) - 12'(r1);
        else hn1s = 12'(4 * dd1) + 12'(r1) - 12'(g1);
        if (hn1s[11]) hn1s = hn1s + 12'(6 * dd1);
    end
    // Stage 3: inverted L, S, H by reciprocal multiplication.
    logic [23:0] c3_reg; logic inv3_reg, grey3_reg;
    logic [W-1:0] li3_reg, s3_reg, h3_reg;
    logic [F+18:0] pl2;
    logic [F+24:0] ps2;
    logic [F+30:0] ph2;
    assign pl2 = (F+19)'(sum2_reg) * (F+19)'(ML);
    assign ps2 = (F+25)'(dd2_reg) * (F+25)'(rs2_reg);
    assign ph2 = (F+31)'(hn2_reg) * (F+31)'(rh2_reg);
    // Stage 4: t1, t2. Stage 5: channel values. Stage 6: bytes. Stage 7: output.
    logic [23:0] c4_reg; logic inv4_reg, grey4_reg;
    logic signed [W+1:0] t1_4_reg, t2_4_reg, h4_reg, li4_reg;
    logic [23:0] c5_reg; logic inv5_reg, grey5_reg;
    logic signed [W+1:0] pr5_reg, pg5_reg, pb5_reg, li5_reg;
    logic [23:0] c6_reg, out_reg;
    logic signed [W+1:0] li3s, s3s, lis3, t1_3, tr, tb;
    assign li3s = (W+2)'(li3_reg);
    assign s3s  = (W+2)'(s3_reg);
    assign lis3 = fmul(li3s, s3s);
    assign t1_3 = (li3s < (ONE >>> 1)) ? li3s + lis3 : li3s + s3s - lis3;
    always_comb
    begin
        tr = h4_reg + (W+2)'(THIRD); if (tr > ONE) tr = tr - (W+2)'(ONE);
        tb = h4_reg - (W+2)'(THIRD); if (tb < 0)   tb = tb + (W+2)'(ONE);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= s_axis_tdata; mx1_reg <= mx0; mn1_reg <= mn0;
            inv1_reg <= dark_reg || (s_axis_tuser && contrast_reg);
            c2_reg <= c1_reg; inv2_reg <= inv1_reg;
            grey2_reg <= (dd1 == 8'd0);
            sum2_reg <= sum1; dd2_reg <= dd1; hn2_reg <= hn1s[10:0];
            rs2_reg <= rcp_s[dens1]; rh2_reg <= rcp_h[dd1];
            c3_reg <= c2_reg; inv3_reg <= inv2_reg; grey3_reg <= grey2_reg;
            li3_reg <= W'(ONE) - W'(pl2[F+18:18]);
            s3_reg <= grey2_reg ? '0 : W'(ps2[F+16:16]);
            h3_reg <= grey2_reg ? '0 : W'(ph2[F+22:22]);
            c4_reg <= c3_reg; inv4_reg <= inv3_reg; grey4_reg <= grey3_reg;
            li4_reg <= li3s; h4_reg <= (W+2)'(h3_reg);
            t1_4_reg <= t1_3;
            t2_4_reg <= li3s + li3s - t1_3;
            c5_reg <= c4_reg; inv5_reg <= inv4_reg; grey5_reg <= grey4_reg;
            li5_reg <= li4_reg;
            pr5_reg <= chan(t1_4_reg, t2_4_reg, tr);
            pg5_reg <= chan(t1_4_reg, t2_4_reg, h4_reg);
            pb5_reg <= chan(t1_4_reg, t2_4_reg, tb);
            if (!inv5_reg) c6_reg <= c5_reg;
            else if (grey5_reg)
                c6_reg <= {tobyte(li5_reg), tobyte(li5_reg), tobyte(li5_reg)};
            else c6_reg <= {tobyte(pb5_reg), tobyte(pg5_reg), tobyte(pr5_reg)};
            out_reg <= c6_reg;
        end
    end
    assign m_axis_tdata = out_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg) && $stable(out_reg))
        else $error("pipeline moved during stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready with empty output");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat lost");
endmodule
`default_nettype wire

[sim/theme_color_lightness_invert_tb.sv]
// Self-checking testbench for theme_color_lightness_invert: a fixed-point HSL
// lightness-inversion predictor feeds a queue that every output beat is checked against.
// Depends on tcli_pkg and the theme_color_lightness_invert RTL.
`timescale 1ns / 100ps
`default_nettype none
module theme_color_lightness_invert_tb;
    import tcli_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE = longint'(1) << FRAC;
    localparam longint HALF = longint'(1) << (FRAC - 1);
    localparam longint THIRD = (longint'(33333) << FRAC) / 100000;
    localparam longint TWO3 = (longint'(66666) << FRAC) / 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic        cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    logic [23:0] expected_colors[$];
    int          mismatches = 0;
    bit          send_idle_en = 1'b1;
    bit          recv_idle_en = 1'b1;
    bit          dark_mode = 1'b0;
    bit          contrast_mode = 1'b0;

    always #5 clk = ~clk;

    theme_color_lightness_invert #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // color_in[23:0]
        .s_axis_tuser(s_axis_tuser),   // fixed_flag
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)    // color_out[23:0]
    );

    function automatic longint fx_mul(longint a, longint b);
        bit neg;
        longint m;
        neg = (a < 0) != (b < 0);
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> FRAC;
        return neg ? -m : m;
    endfunction

    function automatic logic [7:0] to_byte(longint p);
        if (p <= 0) return 8'd0;
        if (p >= ONE) return 8'd255;
        return 8'((p * 255) >>> FRAC);
    endfunction

    function automatic longint hue_channel(longint t1, longint t2, longint t);
        if (t * 6 < ONE) return t2 + fx_mul((t1 - t2) * 6, t);
        if (t * 2 < ONE) return t1;
        if (t * 3 < 2 * ONE) return t2 + fx_mul((t1 - t2) * 6, TWO3 - t);
        return t2;
    endfunction

    function automatic logic [23:0] invert_lightness(logic [23:0] c);
        longint r, g, b, mx, mn, d, sum, li, sq, num, hq, t1, t2, t;
        logic [7:0] rb, gb, bb;
        r = longint'(c[7:0]); g = longint'(c[15:8]); b = longint'(c[23:16]);
        mx = (r >= g && r >= b) ? r : (g >= b ? g : b);
        mn = (r <= g && r <= b) ? r : (g <= b ? g : b);
        sum = mx + mn;
        d = mx - mn;
        li = ONE - (sum * ONE) / LUM_DEN;
        if (d == 0)
        begin
            rb = to_byte(li);
            return {rb, rb, rb};
        end
        sq = (sum < BYTE_MAX) ? (d * ONE) / sum : (d * ONE) / (LUM_DEN - sum);
        if (mx == r) num = g - b;
        else if (mx == g) num = 2 * d + (b - r);
        else num = 4 * d + (r - g);
        if (num < 0) num += 6 * d;
        hq = (num * ONE) / (6 * d);
        if (li < HALF) t1 = li + fx_mul(li, sq);
        else t1 = li + sq - fx_mul(li, sq);
        t2 = 2 * li - t1;
        t = hq + THIRD;
        if (t > ONE) t -= ONE;
        rb = to_byte(hue_channel(t1, t2, t));
        gb = to_byte(hue_channel(t1, t2, hq));
        t = hq - THIRD;
        if (t < 0) t += ONE;
        bb = to_byte(hue_channel(t1, t2, t));
        return {bb, gb, rb};
    endfunction

    task automatic write_reg(int idx, bit val);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ADDR_W'(idx);
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_DARK_ENABLE) dark_mode = val;
        else if (idx == CFG_CONTRAST_DARK) contrast_mode = val;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_mode(bit dark, bit contrast);
        drain();
        write_reg(CFG_DARK_ENABLE, dark);
        write_reg(CFG_CONTRAST_DARK, contrast);
    endtask

    task automatic send_color(logic [23:0] color, bit fixed);
        if (send_idle_en && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= color;
        s_axis_tuser <= fixed;
        expected_colors.push_back((dark_mode || (fixed && contrast_mode)) ?
                                  invert_lightness(color) : color);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random(int n);
        logic [23:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = 24'($urandom);
            // Exact greys exercise the grey short path.
            if ($urandom_range(0, 9) == 0) c = {3{c[7:0]}};
            send_color(c, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_passthrough;
        set_mode(1'b0, 1'b0);
        send_color(24'h000000, 1'b1);
        send_color(24'hFFFFFF, 1'b0);
        send_random(40);
    endtask

    task automatic test_dark_directed;
        logic [23:0] colors[] = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF,
            24'h00FF00, 24'hFF0000, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
            24'h7F7F80, 24'h010000, 24'hFEFFFF, 24'h123456, 24'hAA5501,
            24'h3399CC, 24'h405060, 24'h7F0080};
        set_mode(1'b1, 1'b0);
        foreach (colors[i]) send_color(colors[i], i[0]);
    endtask

    task automatic test_contrast_flag;
        set_mode(1'b0, 1'b1);
        send_color(24'h3399CC, 1'b1);
        send_color(24'h3399CC, 1'b0);
        send_random(200);
    endtask

    task automatic test_random_modes;
        set_mode(1'b1, 1'b1);
        send_random(300);
        // Let everything drain before the next beat.
        drain();
        send_random(200);
        set_mode(1'b1, 1'b0);
        send_random(150);
    endtask

    task automatic test_full_rate;
        set_mode(1'b0, 1'b1);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        send_random(150);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
            end
            else
            begin
                if (m_axis_tdata !== expected_colors[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: expected %h, got %h",
                                 expected_colors[0], m_axis_tdata);
                end
                void'(expected_colors.pop_front());
            end
        end
    end

    // Output stall bursts.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (recv_idle_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough();
        test_dark_directed();
        test_contrast_flag();
        test_random_modes();
        test_full_rate();
        drain();
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
src/tcli_pkg.sv
src/theme_color_lightness_invert.sv
sim/theme_color_lightness_invert_tb.sv
